@@ hw/rtl/ep2c_pkg.sv @@
// Shared types, constants and tables for the epoch-to-calendar converter.
`timescale 1ns / 1ps
`default_nettype none

package ep2c_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 11;
    localparam int STEP_CNT_W = 6;

    localparam logic [STEP_CNT_W-1:0] DIV_STEPS = STEP_CNT_W'(DIVIDEND_W);

    localparam logic [DIVISOR_W-1:0] SECS_PER_MIN   = 11'd60;
    localparam logic [DIVISOR_W-1:0] MINS_PER_HOUR  = 11'd60;
    localparam logic [DIVISOR_W-1:0] HOURS_PER_DAY  = 11'd24;
    localparam logic [DIVISOR_W-1:0] DAYS_PER_CYCLE = 11'd1461;
    localparam logic [DIVISOR_W-1:0] DAYS_COMMON    = 11'd365;
    localparam logic [DIVISOR_W-1:0] DAYS_TWO_YEARS = 11'd730;
    localparam logic [DIVISOR_W-1:0] DAYS_LEAP_END  = 11'd1096;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    localparam logic [31:0] LIMIT_SECONDS = 32'd4102444800;
    localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [19:0] micros_in;
    } ep2c_in_t;

    typedef struct packed {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] calendar_year;
        logic [19:0] micros_out;
        logic        leap_year;
        logic        out_of_range;
    } ep2c_out_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } ep2c_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } ep2c_div_rsp_t;

    // Month length by zero-based month index.
    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        begin
            unique case (idx)
                4'd1:                      len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/epoch_seconds_to_calendar_core.sv @@
// Top level: epoch seconds to calendar date and time of day.
`timescale 1ns / 1ps
`default_nettype none

// Converts a seconds count since 1970-01-01 into second, minute, hour, day,
// month and year, passing the microsecond field through. One item is in
// flight at a time. The steps, in order: four passes through the shared
// bit-serial divider (by 60, 60, 24 and 1461), the year split, a walk that
// examines the months one at a time (1 to 12 of them), and the load of the
// output register.
// The output register lets a new item be accepted while the previous result
// is still stalled. Dates after 2099 set out_of_range; the other fields are
// then computed with 2100 taken as a leap year.
module epoch_seconds_to_calendar_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ep2c_pkg::ep2c_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ep2c_pkg::ep2c_out_t     out_data
);
    import ep2c_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_YEAR  = 5'b00100,
        S_MONTH = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        PH_SEC  = 4'b0001,
        PH_MIN  = 4'b0010,
        PH_HOUR = 4'b0100,
        PH_CYC  = 4'b1000
    } phase_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [5:0]    sec_reg, sec_next;
    logic [5:0]    min_reg, min_next;
    logic [4:0]    hour_reg, hour_next;
    logic [5:0]    cyc_reg, cyc_next;
    logic [DIVISOR_W-1:0] dayrem_reg, dayrem_next;
    logic [3:0]    month_reg, month_next;
    logic [11:0]   year_reg, year_next;
    logic          leap_reg, leap_next;
    logic [19:0]   micros_reg, micros_next;
    logic          oor_reg, oor_next;
    logic          out_valid_reg, out_valid_next;
    ep2c_out_t     out_data_reg, out_data_next;

    ep2c_div_req_t div_req;
    ep2c_div_rsp_t div_rsp;
    logic [4:0]    cur_len;
    logic [1:0]    year_off;

    ep2c_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cur_len = month_len(month_reg, leap_reg);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        cyc_next       = cyc_reg;
        dayrem_next    = dayrem_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        leap_next      = leap_reg;
        micros_next    = micros_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = SECS_PER_MIN;
        year_off         = 2'd0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = in_data.epoch_seconds;
                    div_req.divisor  = SECS_PER_MIN;
                    micros_next      = in_data.micros_in;
                    oor_next         = (in_data.epoch_seconds >= LIMIT_SECONDS);
                    phase_next       = PH_SEC;
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    unique case (phase_reg)
                        PH_SEC:
                        begin
                            sec_next        = div_rsp.remainder[5:0];
                            div_req.start   = 1'b1;
                            div_req.divisor = MINS_PER_HOUR;
                            phase_next      = PH_MIN;
                        end
                        PH_MIN:
                        begin
                            min_next        = div_rsp.remainder[5:0];
                            div_req.start   = 1'b1;
                            div_req.divisor = HOURS_PER_DAY;
                            phase_next      = PH_HOUR;
                        end
                        PH_HOUR:
                        begin
                            hour_next       = div_rsp.remainder[4:0];
                            div_req.start   = 1'b1;
                            div_req.divisor = DAYS_PER_CYCLE;
                            phase_next      = PH_CYC;
                        end
                        PH_CYC:
                        begin
                            // at most 34 whole four-year cycles fit in 32 bits of seconds
                            cyc_next    = div_rsp.quotient[5:0];
                            dayrem_next = div_rsp.remainder;
                            state_next  = S_YEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_YEAR:
            begin
                leap_next = 1'b0;
                priority if (dayrem_reg < DAYS_COMMON)
                begin
                    year_off = 2'd0;
                end
                else if (dayrem_reg < DAYS_TWO_YEARS)
                begin
                    year_off    = 2'd1;
                    dayrem_next = dayrem_reg - DAYS_COMMON;
                end
                else if (dayrem_reg < DAYS_LEAP_END)
                begin
                    year_off    = 2'd2;
                    leap_next   = 1'b1;
                    dayrem_next = dayrem_reg - DAYS_TWO_YEARS;
                end
                else
                begin
                    year_off    = 2'd3;
                    dayrem_next = dayrem_reg - DAYS_LEAP_END;
                end
                year_next  = EPOCH_YEAR + 12'({cyc_reg, 2'b00}) + 12'(year_off);
                month_next = '0;
                state_next = S_MONTH;
            end
            S_MONTH:
            begin
                if ((month_reg < LAST_MONTH_IDX) && ({6'd0, cur_len} <= dayrem_reg))
                begin
                    dayrem_next = dayrem_reg - {6'd0, cur_len};
                    month_next  = month_reg + 4'd1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.second_of_minute = sec_reg;
                    out_data_next.minute_of_hour   = min_reg;
                    out_data_next.hour_of_day      = hour_reg;
                    out_data_next.day_of_month     = dayrem_reg[4:0] + 5'd1;
                    out_data_next.month_number     = month_reg + 4'd1;
                    out_data_next.calendar_year    = year_reg;
                    out_data_next.micros_out       = micros_reg;
                    out_data_next.leap_year        = leap_reg;
                    out_data_next.out_of_range     = oor_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SEC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg      <= sec_next;
        min_reg      <= min_next;
        hour_reg     <= hour_next;
        cyc_reg      <= cyc_next;
        dayrem_reg   <= dayrem_next;
        month_reg    <= month_next;
        year_reg     <= year_next;
        leap_reg     <= leap_next;
        micros_reg   <= micros_next;
        oor_reg      <= oor_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_state_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg) && $onehot(phase_reg))
        else $error("state or phase not one-hot");

    a_month_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> (month_reg <= LAST_MONTH_IDX && dayrem_reg < 11'd366))
        else $error("month search out of bounds");

    a_result_sane : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.day_of_month != 5'd0 &&
                           out_data_reg.month_number != 4'd0 &&
                           out_data_reg.month_number <= 4'd12))
        else $error("result date out of range");

endmodule

`default_nettype wire

@@ hw/rtl/ep2c_sdiv.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ep2c_sdiv (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ep2c_pkg::ep2c_div_req_t req,
    output ep2c_pkg::ep2c_div_rsp_t      rsp
);
    import ep2c_pkg::*;

    logic [DIVIDEND_W-1:0] shift_reg, shift_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic                  qbit;

    // Dividend bits leave at the top of shift_reg while quotient bits enter at the bottom.
    always_comb
    begin
        trial      = {rem_reg, shift_reg[DIVIDEND_W-1]};
        qbit       = (trial >= {1'b0, div_reg});
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            shift_next = req.dividend;
            rem_next   = '0;
            div_next   = req.divisor;
            cnt_next   = DIV_STEPS;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[DIVIDEND_W-2:0], qbit};
            rem_next   = qbit ? DIVISOR_W'(trial - {1'b0, div_reg}) : trial[DIVISOR_W-1:0];
            cnt_next   = cnt_reg - STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = shift_reg;
    assign rsp.remainder = rem_reg;

    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_rem_below_div : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted mid-division");

endmodule

`default_nettype wire

@@ test/tb_epoch_seconds_to_calendar_core.sv @@
// Self-checking testbench for the epoch seconds to calendar date converter.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_core;

    import ep2c_pkg::*;

    localparam int          RANDOM_ITEMS  = 850;
    localparam int          IDLE_LIMIT    = 5000;
    localparam int          DRAIN_CYCLES  = 160;
    localparam int          SHOWN_ERRORS  = 30;
    localparam logic [31:0] END_OF_2099   = 32'd4102444800;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic        KNOWN         = 1'b1;
    localparam logic        PREDICT       = 1'b0;
    localparam int          ROWS          = 24;

    // One directed row: input, whether the result is typed in, and that result.
    typedef struct packed {
        logic [31:0] epoch;
        logic [19:0] micros;
        logic        typed;
        ep2c_out_t   want;
    } date_row_t;

    // want fields: sec, min, hour, day, month, year, micros, leap, past 2099
    date_row_t directed_rows [ROWS] = '{
        {32'd0, 20'd0, KNOWN,
            6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 12'd1970, 20'd0, 1'b0, 1'b0},
        {32'hFFFF_FFFF, 20'hFFFFF, KNOWN,
            6'd15, 6'd28, 5'd6, 5'd6, 4'd2, 12'd2106, 20'hFFFFF, 1'b0, 1'b1},
        {32'd4102444799, 20'd999999, KNOWN,
            6'd59, 6'd59, 5'd23, 5'd31, 4'd12, 12'd2099, 20'd999999, 1'b0, 1'b0},
        {32'd4102444800, 20'd0, KNOWN,
            6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 12'd2100, 20'd0, 1'b1, 1'b1},
        // last second of January: day 31, not day 32
        {32'd2678399, 20'd500000, KNOWN,
            6'd59, 6'd59, 5'd23, 5'd31, 4'd1, 12'd1970, 20'd500000, 1'b0, 1'b0},
        {32'd68169600, 20'd1, KNOWN,
            6'd0, 6'd0, 5'd0, 5'd29, 4'd2, 12'd1972, 20'd1, 1'b1, 1'b0},
        {32'd68169599, 20'd7, PREDICT, 60'd0},
        {32'd86399, 20'd999998, PREDICT, 60'd0},
        {32'd31449600, 20'd3, PREDICT, 60'd0},
        {32'd31535999, 20'd4, PREDICT, 60'd0},
        {32'd31536000, 20'd5, PREDICT, 60'd0},
        {32'd63071999, 20'd6, PREDICT, 60'd0},
        {32'd63072000, 20'd8, PREDICT, 60'd0},
        {32'd94607999, 20'd9, PREDICT, 60'd0},
        {32'd94694399, 20'd10, PREDICT, 60'd0},
        {32'd94694400, 20'd11, PREDICT, 60'd0},
        {32'd126230399, 20'd12, PREDICT, 60'd0},
        {32'd126230400, 20'd13, PREDICT, 60'd0},
        {32'd951782400, 20'd14, PREDICT, 60'd0},
        {32'd2147483647, 20'h55555, PREDICT, 60'd0},
        {32'd2147483648, 20'hAAAAA, PREDICT, 60'd0},
        {32'd4102444801, 20'd1000000, PREDICT, 60'd0},
        // Feb 29 of 2100 exists under the four-year scheme
        {32'd4107542400, 20'd15, PREDICT, 60'd0},
        {32'd1700000000, 20'd123456, PREDICT, 60'd0}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    ep2c_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    ep2c_out_t out_data;

    ep2c_in_t  timestamp_q [$];
    ep2c_out_t pending_dates [$];

    int        next_item    = 0;
    int        sent_count   = 0;
    int        burst_left   = 1;
    int        gap_left     = 0;
    int        stall_mode   = 0;
    int        stall_span   = 0;
    int        idle_cycles  = 0;
    int        mismatches   = 0;
    int        checked      = 0;
    int        past_2099    = 0;
    int        leap_dates   = 0;

    epoch_seconds_to_calendar_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Calendar date under the four-year cycle, 2100 counted as leap.
    function automatic ep2c_out_t civil_from_epoch(input ep2c_in_t item);
        logic [31:0] t;
        logic [31:0] days;
        logic [31:0] quads;
        logic [10:0] doff;
        logic [4:0]  mlen;
        logic        walk_done;
        ep2c_out_t   r;
        begin
            t = item.epoch_seconds;
            r.second_of_minute = 6'(t % 60);
            t = t / 60;
            r.minute_of_hour = 6'(t % 60);
            t = t / 60;
            r.hour_of_day = 5'(t % 24);
            days = t / 24;
            quads = days / 1461;
            doff = 11'(days % 1461);
            r.leap_year = 1'b0;
            if (doff < 730)
            begin
                r.calendar_year = 12'(32'd1970 + 4 * quads + doff / 365);
                doff = 11'(doff % 365);
            end
            else if (doff < 1096)
            begin
                r.leap_year = 1'b1;
                r.calendar_year = 12'(32'd1972 + 4 * quads);
                doff = doff - 11'd730;
            end
            else
            begin
                r.calendar_year = 12'(32'd1973 + 4 * quads);
                doff = doff - 11'd1096;
            end
            r.month_number = 4'd1;
            walk_done = 1'b0;
            for (int m = 1; m < 12; m++)
            begin
                case (m)
                    2:             mlen = r.leap_year ? 5'd29 : 5'd28;
                    4, 6, 9, 11:   mlen = 5'd30;
                    default:       mlen = 5'd31;
                endcase
                if (!walk_done && {6'd0, mlen} <= doff)
                begin
                    doff = doff - {6'd0, mlen};
                    r.month_number = 4'(m + 1);
                end
                else
                begin
                    walk_done = 1'b1;
                end
            end
            r.day_of_month = 5'(doff + 1);
            r.micros_out = item.micros_in;
            r.out_of_range = (item.epoch_seconds >= END_OF_2099);
            return r;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        begin
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    // Sender: bursts of items with random gaps; a stalled item is held.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (sent_count < ROWS && directed_rows[sent_count].typed)
                    pending_dates.push_back(directed_rows[sent_count].want);
                else
                    pending_dates.push_back(civil_from_epoch(in_data));
                sent_count <= sent_count + 1;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (next_item < timestamp_q.size())
                begin
                    in_valid  <= 1'b1;
                    in_data   <= timestamp_q[next_item];
                    next_item <= next_item + 1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(16, 1);
                        gap_left   <= $urandom_range(1, 0) ? 0 : $urandom_range(200, 1);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: free-flowing, random, or long held stalls, switching spans.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(2, 0);
            stall_span <= $urandom_range(150, 10);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(1, 0));
            default: out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        ep2c_out_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result %h arrived with no item pending", $time, out_data);
            end
            else
            begin
                want = pending_dates.pop_front();
                checked++;
                past_2099  += want.out_of_range;
                leap_dates += want.leap_year;
                check_field("second_of_minute", 32'(want.second_of_minute),
                            32'(out_data.second_of_minute));
                check_field("minute_of_hour", 32'(want.minute_of_hour),
                            32'(out_data.minute_of_hour));
                check_field("hour_of_day", 32'(want.hour_of_day), 32'(out_data.hour_of_day));
                check_field("day_of_month", 32'(want.day_of_month),
                            32'(out_data.day_of_month));
                check_field("month_number", 32'(want.month_number),
                            32'(out_data.month_number));
                check_field("calendar_year", 32'(want.calendar_year),
                            32'(out_data.calendar_year));
                check_field("micros_out", 32'(want.micros_out), 32'(out_data.micros_out));
                check_field("leap_year", 32'(want.leap_year), 32'(out_data.leap_year));
                check_field("out_of_range", 32'(want.out_of_range),
                            32'(out_data.out_of_range));
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        ep2c_in_t    item;
        int          pick;
        logic [31:0] day_start;
        for (int i = 0; i < ROWS; i++)
        begin
            item.epoch_seconds = directed_rows[i].epoch;
            item.micros_in     = directed_rows[i].micros;
            timestamp_q.push_back(item);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(99, 0);
            day_start = $urandom_range(47481, 0) * SECS_PER_DAY;
            if (pick < 55)
                item.epoch_seconds = $urandom_range(32'd4102444799, 32'd0);
            else if (pick < 70)
                item.epoch_seconds = day_start + ($urandom_range(1, 0) ? 32'd0 : 32'd1);
            else if (pick < 85)
                item.epoch_seconds = day_start + SECS_PER_DAY - $urandom_range(2, 1);
            else if (pick < 93)
                item.epoch_seconds = $urandom_range(32'hFFFF_FFFF, END_OF_2099);
            else
                item.epoch_seconds = $urandom;
            if ($urandom_range(99, 0) < 85)
                item.micros_in = 20'($urandom_range(999999, 0));
            else
                item.micros_in = 20'($urandom_range(20'hFFFFF, 0));
            timestamp_q.push_back(item);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (!(sent_count == timestamp_q.size() && pending_dates.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d timestamps (%0d directed, %0d random).",
                 checked, ROWS, RANDOM_ITEMS);
        $display("%0d fell past 2099, %0d landed in leap years, %0d field mismatches.",
                 past_2099, leap_dates, mismatches);
        if (mismatches == 0 && pending_dates.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
